FILE: rtl/json_byte_stream_tokenizer_top_assert.svh
// assertion helpers for the tokenizer top level
// both sample on clk and stay quiet while rst is high
`ifndef JSON_BYTE_STREAM_TOKENIZER_TOP_ASSERT_SVH
`define JSON_BYTE_STREAM_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication
`define JBT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/jbt_pkg.sv
package jbt_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  // tokens one byte can cause at most
  localparam int SLOTS = 3;

  localparam logic [31:0] START_FIELD_MAX = '1;
  localparam logic [15:0] LENGTH_FIELD_MAX = '1;
  localparam logic [15:0] FRAC_COUNT_MAX = '1;

  // characters
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LOW_B   = 8'h62;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam logic [39:0] TXT_NULL  = {"null", 8'h00};
  localparam logic [39:0] TXT_TRUE  = {"true", 8'h00};
  localparam logic [39:0] TXT_FALSE = "false";

  typedef enum logic [2:0] {
    M_IDLE, M_INT, M_FRAC, M_STR, M_ESC, M_LIT
  } lex_mode_t;

  typedef enum logic [1:0] {
    LIT_NULL, LIT_TRUE, LIT_FALSE
  } lit_id_t;

  typedef enum logic [3:0] {
    TK_UNKNOWN    = 4'd0,
    TK_BAD_ESC    = 4'd1,
    TK_EOF        = 4'd2,
    TK_LBRACE     = 4'd3,
    TK_RBRACE     = 4'd4,
    TK_LBRACK     = 4'd5,
    TK_RBRACK     = 4'd6,
    TK_COLON      = 4'd7,
    TK_COMMA      = 4'd8,
    TK_FRACTIONAL = 4'd9,
    TK_INTEGER    = 4'd10,
    TK_TRUE       = 4'd11,
    TK_FALSE      = 4'd12,
    TK_NULL       = 4'd13,
    TK_STRING     = 4'd14
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] start;
    logic [15:0] length;
    logic [63:0] int_part;
    logic [63:0] frac_digits;
    logic [15:0] frac_count;
    logic        neg;
    logic        last;
  } token_t;

  // tokens from one byte, in order; slots may be empty
  typedef struct packed {
    logic [SLOTS-1:0]   valid;
    token_t [SLOTS-1:0] tok;
  } push_t;

  typedef struct packed {
    logic room;
    logic nonempty;
  } q_status_t;

  function automatic logic [39:0] lit_text(lit_id_t id);
    logic [39:0] t;
    case (id)
      LIT_NULL:  t = TXT_NULL;
      LIT_TRUE:  t = TXT_TRUE;
      LIT_FALSE: t = TXT_FALSE;
      default:   t = TXT_NULL;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] lit_char(lit_id_t id, logic [2:0] idx);
    logic [39:0] t;
    logic [7:0]  ch;
    t = lit_text(id);
    case (idx)
      3'd0:    ch = t[39:32];
      3'd1:    ch = t[31:24];
      3'd2:    ch = t[23:16];
      3'd3:    ch = t[15:8];
      3'd4:    ch = t[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(lit_id_t id);
    logic [2:0] n;
    case (id)
      LIT_FALSE: n = 3'd5;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic tok_kind_t lit_kind(lit_id_t id);
    tok_kind_t k;
    case (id)
      LIT_TRUE:  k = TK_TRUE;
      LIT_FALSE: k = TK_FALSE;
      default:   k = TK_NULL;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/jbt_ifs.sv
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jbt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic [63:0] integer_part;
  logic [63:0] fraction_digits;
  logic [15:0] fraction_count;
  logic        is_negative;
  logic        last_result;

  modport source (
    output valid, output token_kind, output token_start, output token_length,
    output integer_part, output fraction_digits, output fraction_count,
    output is_negative, output last_result, input ready
  );
  modport sink (
    input valid, input token_kind, input token_start, input token_length,
    input integer_part, input fraction_digits, input fraction_count,
    input is_negative, input last_result, output ready
  );
endinterface

FILE: rtl/json_byte_stream_tokenizer_top.sv
// json byte stream tokenizer
// in_ch carries the text, one byte per transfer, with end_of_input set on its
// last byte. out_ch carries tokens: kind, start offset, length and, for numbers,
// integer part, fraction digits, fraction digit count and sign. last_result
// marks the final token that a byte causes; a byte may cause none to three.
// the lexer takes a byte per cycle while the queue has room and writes its
// tokens into a token queue in the same cycle; the first reaches out_ch via its
// queue entry and the output register, later ones follow one per cycle while
// the receiver takes them. throughput is one byte per cycle as long as bytes
// average at most one token and the receiver stays ready; out_ch moves one
// token per cycle, so bursts of punctuation plus end of input are paced by out_ch.
// in_ch.ready is low while the queue has fewer than three free entries, so a
// stalled receiver fills the queue and then holds the sender off; nothing is
// dropped and the waiting token stays on out_ch unchanged.
// rst clears the lexer to between-token state at offset zero and empties the
// queue. end of input flushes any pending token, emits eof and restarts the
// offset at zero for the next text.
`include "json_byte_stream_tokenizer_top_assert.svh"

module json_byte_stream_tokenizer_top #(
  parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = jbt_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = jbt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  jbt_in_if.sink     in_ch,
  jbt_out_if.source  out_ch
);
  import jbt_pkg::*;

  push_t     push;      // tokens from the front end, up to three per byte
  q_status_t q_stat;    // queue has room / has a token
  token_t    q_head;    // oldest queued token
  logic      q_pop;     // back end takes the head

  // front end: classifies each byte and keeps the lexing state
  jbt_lexer #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_lexer (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .room  (q_stat.room),
    .push  (push)
  );

  // short token queue decoupling the two sides
  jbt_tok_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (q_pop),
    .head (q_head),
    .stat (q_stat)
  );

  // back end: registered output towards the receiver
  jbt_emitter u_emitter (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .stat   (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // eof always closes the tokens of its byte
  `JBT_ASSERT_IMPLIES(a_eof_is_last, out_ch.valid && out_ch.token_kind == TK_EOF, out_ch.last_result, "eof token without last flag")

  // the last byte of a text always leaves at least the eof token queued
  `JBT_ASSERT_NEXT(a_eoi_queues_token, in_ch.valid && in_ch.ready && in_ch.end_of_input, q_stat.nonempty, "end of input left the queue empty")

  // numeric fields stay clear on tokens that are not numbers
  `JBT_ASSERT_IMPLIES(a_plain_no_number, out_ch.valid && out_ch.token_kind != TK_FRACTIONAL && out_ch.token_kind != TK_INTEGER, out_ch.integer_part == '0 && out_ch.fraction_digits == '0 && out_ch.fraction_count == '0 && !out_ch.is_negative, "number fields set on a non-number token")

endmodule

FILE: rtl/jbt_lexer.sv
module jbt_lexer #(
  parameter int OFFSET_BITS = jbt_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = jbt_pkg::LENGTH_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  jbt_in_if.sink         in_ch,
  input  logic           room,
  output jbt_pkg::push_t push
);
  import jbt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // lexer state
  lex_mode_t              mode;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0] run_length;
  logic [63:0]            int_accum;
  logic [63:0]            frac_accum;
  logic [15:0]            frac_cnt;
  logic                   minus_seen;
  lit_id_t                lit_id;
  logic [2:0]             lit_cnt;
  logic                   esc_err;

  // state after the byte itself, before end of input is applied
  lex_mode_t              mode_mid;
  logic [OFFSET_BITS-1:0] start_mid;
  logic [LENGTH_BITS-1:0] run_mid;
  logic [63:0]            int_mid;
  logic [63:0]            frac_mid;
  logic [15:0]            fcnt_mid;
  logic                   minus_mid;
  lit_id_t                lit_id_mid;
  logic [2:0]             lit_cnt_mid;
  logic                   esc_mid;

  lex_mode_t              mode_next;
  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic [OFFSET_BITS-1:0] start_offset_next;
  logic [LENGTH_BITS-1:0] run_length_next;
  logic [63:0]            int_accum_next;
  logic [63:0]            frac_accum_next;
  logic [15:0]            frac_cnt_next;
  logic                   minus_seen_next;
  lit_id_t                lit_id_next;
  logic [2:0]             lit_cnt_next;
  logic                   esc_err_next;

  logic                   accept;
  logic [7:0]             c;
  logic                   eoi;
  logic                   is_digit;
  logic [3:0]             digit_val;
  logic                   num_mode;
  logic                   num_cont;
  logic [2:0]             cur_len;
  logic [2:0]             lit_cnt_inc;
  logic                   lit_match;
  logic                   lit_done;
  logic                   esc_ok;
  logic                   do_idle;
  logic [OFFSET_BITS-1:0] off_inc_sat;
  logic [LENGTH_BITS-1:0] run_inc;
  logic [63:0]            int_mul;
  logic [63:0]            frac_mul;
  logic [15:0]            frac_cnt_inc;

  logic                   idle_emit;
  tok_kind_t              idle_kind;
  logic                   idle_str;
  logic                   idle_lit;
  logic                   idle_num;
  lit_id_t                idle_lit_id;

  token_t                 tok_a;
  token_t                 tok_b;
  token_t                 tok_c;
  token_t                 tok_x;
  token_t                 tok_d;
  logic                   a_valid;
  logic                   b_valid;
  logic                   c_valid;
  logic                   x_valid;
  logic                   d_valid;

  function automatic logic [31:0] clamp_off(logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+31:0] wv;
    wv = (OFFSET_BITS+32)'(v);
    return (wv > (OFFSET_BITS+32)'(START_FIELD_MAX)) ? START_FIELD_MAX : wv[31:0];
  endfunction

  function automatic logic [15:0] clamp_len(logic [LENGTH_BITS-1:0] v);
    logic [LENGTH_BITS+15:0] wv;
    wv = (LENGTH_BITS+16)'(v);
    return (wv > (LENGTH_BITS+16)'(LENGTH_FIELD_MAX)) ? LENGTH_FIELD_MAX : wv[15:0];
  endfunction

  function automatic token_t make_tok(tok_kind_t kind, logic [OFFSET_BITS-1:0] start,
                                     logic [LENGTH_BITS-1:0] len, logic [63:0] ip,
                                     logic [63:0] fd, logic [15:0] fc, logic neg);
    token_t t;
    t.kind        = kind;
    t.start       = clamp_off(start);
    t.length      = clamp_len(len);
    t.int_part    = ip;
    t.frac_digits = fd;
    t.frac_count  = fc;
    t.neg         = neg;
    t.last        = 1'b0;
    return t;
  endfunction

  function automatic token_t make_num(logic frac, logic [OFFSET_BITS-1:0] start,
                                     logic [LENGTH_BITS-1:0] len, logic [63:0] ip,
                                     logic [63:0] fd, logic [15:0] fc, logic neg);
    return make_tok(frac ? TK_FRACTIONAL : TK_INTEGER, start, len, ip,
                    frac ? fd : 64'd0, frac ? fc : 16'd0, neg);
  endfunction

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;
  assign c           = in_ch.in_byte;
  assign eoi         = in_ch.end_of_input;

  // byte decode
  assign is_digit     = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit_val    = c[3:0];
  assign num_mode     = (mode == M_INT) || (mode == M_FRAC);
  assign num_cont     = num_mode && (is_digit || ((c == CH_DOT) && (mode == M_INT)));
  assign cur_len      = lit_len(lit_id);
  assign lit_cnt_inc  = lit_cnt + 3'd1;
  assign lit_match    = (lit_cnt < cur_len) && (c == lit_char(lit_id, lit_cnt));
  assign lit_done     = lit_match && (lit_cnt_inc >= cur_len);
  assign esc_ok       = (c == CH_LOW_B) || (c == CH_LOW_F) || (c == CH_LOW_N) ||
                        (c == CH_LOW_R) || (c == CH_LOW_T) || (c == CH_QUOTE) ||
                        (c == CH_BSLASH);
  assign do_idle      = !num_cont && (mode != M_STR) && (mode != M_ESC) &&
                        !((mode == M_LIT) && lit_match);
  assign off_inc_sat  = (byte_offset == OFF_MAX) ? OFF_MAX : byte_offset + OFFSET_BITS'(1);
  assign run_inc      = (run_length == LEN_MAX) ? LEN_MAX : run_length + LENGTH_BITS'(1);
  assign int_mul      = (int_accum << 3) + (int_accum << 1) + {60'd0, digit_val};
  assign frac_mul     = (frac_accum << 3) + (frac_accum << 1) + {60'd0, digit_val};
  assign frac_cnt_inc = (frac_cnt == FRAC_COUNT_MAX) ? FRAC_COUNT_MAX : frac_cnt + 16'd1;

  // what a byte does between tokens
  always_comb begin
    idle_emit   = 1'b0;
    idle_kind   = TK_UNKNOWN;
    idle_str    = 1'b0;
    idle_lit    = 1'b0;
    idle_num    = 1'b0;
    idle_lit_id = LIT_NULL;
    case (c)
      CH_SPACE, CH_TAB, CH_LF: idle_emit = 1'b0;
      CH_LBRACE: begin
        idle_emit = 1'b1;
        idle_kind = TK_LBRACE;
      end
      CH_RBRACE: begin
        idle_emit = 1'b1;
        idle_kind = TK_RBRACE;
      end
      CH_LBRACK: begin
        idle_emit = 1'b1;
        idle_kind = TK_LBRACK;
      end
      CH_RBRACK: begin
        idle_emit = 1'b1;
        idle_kind = TK_RBRACK;
      end
      CH_COLON: begin
        idle_emit = 1'b1;
        idle_kind = TK_COLON;
      end
      CH_COMMA: begin
        idle_emit = 1'b1;
        idle_kind = TK_COMMA;
      end
      CH_QUOTE: idle_str = 1'b1;
      CH_LOW_N: begin
        idle_lit    = 1'b1;
        idle_lit_id = LIT_NULL;
      end
      CH_LOW_T: begin
        idle_lit    = 1'b1;
        idle_lit_id = LIT_TRUE;
      end
      CH_LOW_F: begin
        idle_lit    = 1'b1;
        idle_lit_id = LIT_FALSE;
      end
      default: begin
        if ((c == CH_MINUS) || is_digit) begin
          idle_num = 1'b1;
        end else begin
          idle_emit = 1'b1;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    mode_mid    = mode;
    start_mid   = start_offset;
    run_mid     = run_length;
    int_mid     = int_accum;
    frac_mid    = frac_accum;
    fcnt_mid    = frac_cnt;
    minus_mid   = minus_seen;
    lit_id_mid  = lit_id;
    lit_cnt_mid = lit_cnt;
    esc_mid     = esc_err;

    case (mode)
      M_INT, M_FRAC: begin
        if (is_digit) begin
          if (mode == M_INT) begin
            int_mid = int_mul;
          end else begin
            frac_mid = frac_mul;
            fcnt_mid = frac_cnt_inc;
          end
          run_mid = run_inc;
        end else if ((c == CH_DOT) && (mode == M_INT)) begin
          mode_mid = M_FRAC;
          run_mid  = run_inc;
        end else begin
          mode_mid = M_IDLE;
        end
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          mode_mid = M_IDLE;
        end else begin
          if (c == CH_BSLASH) begin
            mode_mid = M_ESC;
          end
          run_mid = run_inc;
        end
      end
      M_ESC: begin
        run_mid  = run_inc;
        mode_mid = M_STR;
        if (!esc_ok) begin
          esc_mid = 1'b1;
        end
      end
      M_LIT: begin
        if (lit_match && !lit_done) begin
          lit_cnt_mid = lit_cnt_inc;
        end else begin
          mode_mid    = M_IDLE;
          lit_id_mid  = LIT_NULL;
          lit_cnt_mid = 3'd0;
        end
      end
      default: mode_mid = M_IDLE;
    endcase

    if (do_idle) begin
      if (idle_str) begin
        mode_mid  = M_STR;
        start_mid = off_inc_sat;
        run_mid   = '0;
        esc_mid   = 1'b0;
      end else if (idle_lit) begin
        mode_mid    = M_LIT;
        start_mid   = byte_offset;
        lit_id_mid  = idle_lit_id;
        lit_cnt_mid = 3'd1;
      end else if (idle_num) begin
        mode_mid  = M_INT;
        start_mid = byte_offset;
        run_mid   = LENGTH_BITS'(1);
        minus_mid = (c == CH_MINUS);
        int_mid   = (c == CH_MINUS) ? 64'd0 : {60'd0, digit_val};
        frac_mid  = '0;
        fcnt_mid  = '0;
      end
    end

    // end of input: everything back to reset, next byte is offset zero
    if (eoi) begin
      mode_next         = M_IDLE;
      byte_offset_next  = '0;
      start_offset_next = '0;
      run_length_next   = '0;
      int_accum_next    = '0;
      frac_accum_next   = '0;
      frac_cnt_next     = '0;
      minus_seen_next   = 1'b0;
      lit_id_next       = LIT_NULL;
      lit_cnt_next      = 3'd0;
      esc_err_next      = 1'b0;
    end else begin
      mode_next         = mode_mid;
      byte_offset_next  = off_inc_sat;
      start_offset_next = start_mid;
      run_length_next   = run_mid;
      int_accum_next    = int_mid;
      frac_accum_next   = frac_mid;
      frac_cnt_next     = fcnt_mid;
      minus_seen_next   = minus_mid;
      lit_id_next       = lit_id_mid;
      lit_cnt_next      = lit_cnt_mid;
      esc_err_next      = esc_mid;
    end
  end

  // tokens for this byte
  always_comb begin
    a_valid = 1'b0;
    tok_a   = '0;
    if (num_mode && !num_cont) begin
      a_valid = 1'b1;
      tok_a   = make_num(mode == M_FRAC, start_offset, run_length, int_accum,
                         frac_accum, frac_cnt, minus_seen);
    end else if ((mode == M_STR) && (c == CH_QUOTE)) begin
      a_valid = 1'b1;
      tok_a   = make_tok(esc_err ? TK_BAD_ESC : TK_STRING, start_offset, run_length,
                         64'd0, 64'd0, 16'd0, 1'b0);
    end else if (mode == M_LIT) begin
      if (lit_done) begin
        a_valid = 1'b1;
        tok_a   = make_tok(lit_kind(lit_id), start_offset, LENGTH_BITS'(lit_cnt_inc),
                           64'd0, 64'd0, 16'd0, 1'b0);
      end else if (!lit_match) begin
        // broken literal: unknown over the matched part
        a_valid = 1'b1;
        tok_a   = make_tok(TK_UNKNOWN, start_offset, LENGTH_BITS'(lit_cnt),
                           64'd0, 64'd0, 16'd0, 1'b0);
      end
    end

    b_valid = do_idle && idle_emit;
    tok_b   = make_tok(idle_kind, byte_offset, LENGTH_BITS'(1), 64'd0, 64'd0, 16'd0, 1'b0);

    // pending token cut short by end of input
    c_valid = 1'b0;
    tok_c   = '0;
    if (eoi) begin
      case (mode_mid)
        M_INT, M_FRAC: begin
          c_valid = 1'b1;
          tok_c   = make_num(mode_mid == M_FRAC, start_mid, run_mid, int_mid,
                             frac_mid, fcnt_mid, minus_mid);
        end
        M_STR, M_ESC: begin
          c_valid = 1'b1;
          tok_c   = make_tok(esc_mid ? TK_BAD_ESC : TK_UNKNOWN, start_mid, run_mid,
                             64'd0, 64'd0, 16'd0, 1'b0);
        end
        M_LIT: begin
          c_valid = 1'b1;
          tok_c   = make_tok(TK_UNKNOWN, start_mid, LENGTH_BITS'(lit_cnt_mid),
                             64'd0, 64'd0, 16'd0, 1'b0);
        end
        default: c_valid = 1'b0;
      endcase
    end

    // a byte that emits between tokens leaves nothing pending
    x_valid = b_valid || c_valid;
    tok_x   = b_valid ? tok_b : tok_c;

    d_valid = eoi;
    tok_d   = make_tok(TK_EOF, off_inc_sat, '0, 64'd0, 64'd0, 16'd0, 1'b0);

    if (d_valid) begin
      tok_d.last = 1'b1;
    end else if (x_valid) begin
      tok_x.last = 1'b1;
    end else begin
      tok_a.last = 1'b1;
    end

    push.valid  = accept ? {d_valid, x_valid, a_valid} : '0;
    push.tok[0] = tok_a;
    push.tok[1] = tok_x;
    push.tok[2] = tok_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      byte_offset  <= '0;
      start_offset <= '0;
      run_length   <= '0;
      int_accum    <= '0;
      frac_accum   <= '0;
      frac_cnt     <= '0;
      minus_seen   <= 1'b0;
      lit_id       <= LIT_NULL;
      lit_cnt      <= 3'd0;
      esc_err      <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      byte_offset  <= byte_offset_next;
      start_offset <= start_offset_next;
      run_length   <= run_length_next;
      int_accum    <= int_accum_next;
      frac_accum   <= frac_accum_next;
      frac_cnt     <= frac_cnt_next;
      minus_seen   <= minus_seen_next;
      lit_id       <= lit_id_next;
      lit_cnt      <= lit_cnt_next;
      esc_err      <= esc_err_next;
    end
  end

endmodule

FILE: rtl/jbt_tok_queue.sv
module jbt_tok_queue #(
  parameter int QUEUE_DEPTH = jbt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  jbt_pkg::push_t      push,
  input  logic                pop,
  output jbt_pkg::token_t     head,
  output jbt_pkg::q_status_t  stat
);
  import jbt_pkg::*;

  // depth is a power of two, at least four
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(QUEUE_DEPTH - SLOTS);

  token_t          store [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [AW-1:0]   slot_addr [SLOTS];
  logic [AW-1:0]   fill;
  logic [1:0]      n_push;

  // pack valid slots into consecutive entries
  always_comb begin
    fill = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_addr[i] = wr_ptr + fill;
      if (push.valid[i]) begin
        fill = fill + AW'(1);
      end
    end
  end

  assign n_push        = 2'($countones(push.valid));
  assign head          = store[rd_ptr];
  assign stat.nonempty = (count != '0);
  assign stat.room     = (count <= ROOM_LIMIT);

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (push.valid[i]) begin
        store[slot_addr[i]] <= push.tok[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(n_push) - CW'(pop);
    end
  end

endmodule

FILE: rtl/jbt_emitter.sv
module jbt_emitter (
  input  logic               clk,
  input  logic               rst,
  input  jbt_pkg::token_t    head,
  input  jbt_pkg::q_status_t stat,
  output logic               pop,
  jbt_out_if.source          out_ch
);
  import jbt_pkg::*;

  logic   hold_valid;
  token_t hold;

  // refill the output register whenever it is empty or being taken
  assign pop = stat.nonempty && (!hold_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (pop) begin
      hold_valid <= 1'b1;
    end else if (out_ch.ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= head;
    end
  end

  assign out_ch.valid           = hold_valid;
  assign out_ch.token_kind      = hold.kind;
  assign out_ch.token_start     = hold.start;
  assign out_ch.token_length    = hold.length;
  assign out_ch.integer_part    = hold.int_part;
  assign out_ch.fraction_digits = hold.frac_digits;
  assign out_ch.fraction_count  = hold.frac_count;
  assign out_ch.is_negative     = hold.neg;
  assign out_ch.last_result     = hold.last;

endmodule
